// ===== design/hfbs_pkg.sv =====
// Shared types, widths and helpers for the bilinear heightfield sampler.
// No dependencies; every other design file depends on this package.
package hfbs_pkg;

    localparam int GRID_SIDE_MAX = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int ADDR_W        = 16;
    localparam int COORD_W       = 24;
    localparam int INV_W         = 32;
    localparam int HGT_W         = 20;
    localparam int SIDE_W        = 9;
    localparam int CELL_W        = $clog2(GRID_SIDE_MAX);
    localparam int FRAC_W        = 16;
    localparam int PROD_W        = COORD_W + INV_W + 1;
    localparam int U_W           = 33;
    localparam int F_W           = U_W + CELL_W;
    localparam int ROW_W         = SAMPLE_BITS + FRAC_W + 1;
    localparam int MIXP_W        = ROW_W + FRAC_W + 1;
    localparam int MIX_W         = SAMPLE_BITS + FRAC_W;
    localparam int RES_W         = MIX_W + HGT_W;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH     = 4;
    localparam int OPTR_W        = $clog2(OUT_DEPTH);
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;

    localparam logic signed [PROD_W-1:0] HALF_Q40 = PROD_W'(1) << 40 - 1;
    localparam logic signed [PROD_W-1:0] ONE_Q40  = PROD_W'(1) << 40;
    localparam logic [FRAC_W:0]          ONE_FRAC = (FRAC_W+1)'(1) << FRAC_W;

    localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(2147483);
    localparam logic [HGT_W-1:0]  MAXH_RESET = HGT_W'(25600);
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);

    typedef enum logic [0:0] {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_INV_WORLD_SIZE = 2'd0,
        REG_MAX_HEIGHT     = 2'd1,
        REG_GRID_WIDTH     = 2'd2,
        REG_GRID_HEIGHT    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [INV_W-1:0]  inv_world_size;
        logic [HGT_W-1:0]  max_height;
        logic [SIDE_W-1:0] grid_width;
        logic [SIDE_W-1:0] grid_height;
    } t_cfg;

    // Item as classified by the front end, ready for the memory sequencer.
    typedef struct packed {
        t_kind                       kind;
        logic                        loaded;
        logic [3:0][ADDR_W-1:0]      addr;
        logic [FRAC_W-1:0]           tx;
        logic [FRAC_W-1:0]           tz;
        logic [SAMPLE_BITS-1:0]      value;
    } t_job;

    typedef struct packed {
        t_kind                  kind;
        logic                   loaded;
        logic [ADDR_W-1:0]      idx;
        logic [SAMPLE_BITS-1:0] value;
    } t_tag;

    function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] r);
        logic [SIDE_W-1:0] s;
        s = r;
        if (r < SIDE_W'(2)) begin
            s = SIDE_W'(2);
        end else if (r > SIDE_W'(GRID_SIDE_MAX)) begin
            s = SIDE_W'(GRID_SIDE_MAX);
        end
        return s;
    endfunction

    // Add one half, clamp to [0,1] in Q.40, then drop to Q.32.
    function automatic logic [U_W-1:0] clamp_u(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + HALF_Q40;
        if (s[PROD_W-1]) begin
            s = '0;
        end else if (s > ONE_Q40) begin
            s = ONE_Q40;
        end
        return s[U_W+7:8];
    endfunction

endpackage

// ===== design/hfbs_if.sv =====
// Valid/ready channel interfaces for sampler items and results.
// Depends on hfbs_pkg for field widths.
interface hfbs_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [hfbs_pkg::ADDR_W-1:0]           sample_index;
    logic [hfbs_pkg::SAMPLE_BITS-1:0]      sample_value;
    logic signed [hfbs_pkg::COORD_W-1:0]   query_x;
    logic signed [hfbs_pkg::COORD_W-1:0]   query_z;

    modport source (output valid, kind, sample_index, sample_value, query_x, query_z,
                    input ready);
    modport sink   (input valid, kind, sample_index, sample_value, query_x, query_z,
                    output ready);
endinterface

interface hfbs_out_if;
    logic                          valid;
    logic                          ready;
    logic [hfbs_pkg::HGT_W-1:0]    height;

    modport source (output valid, height, input ready);
    modport sink   (input valid, height, output ready);
endinterface

// ===== design/hfbs_front.sv =====
// Front end: accepts items, maps query coordinates to cells, weights and addresses.
// Depends on hfbs_pkg and hfbs_in_if.
module hfbs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hfbs_in_if.sink              i_in,
    input  hfbs_pkg::t_cfg       i_cfg,
    output logic                 o_job_valid,
    output hfbs_pkg::t_job       o_job,
    input  logic                 i_job_ready
);
    import hfbs_pkg::*;

    logic                     w_adv;
    logic                     r_loaded;
    logic                     r1_v, r2_v, r3_v, r4_v;
    t_tag                     r1_tag, r2_tag, r3_tag;
    logic signed [PROD_W-1:0] r1_px, r1_pz;
    logic [U_W-1:0]           r2_ux, r2_uz;
    logic [F_W-1:0]           r3_fx, r3_fz;
    t_job                     r4_job;

    logic signed [PROD_W-1:0] w_px, w_pz;
    logic [SIDE_W-1:0]        w_w, w_h;
    logic [CELL_W-1:0]        w_wm1, w_hm1;
    logic [CELL_W-1:0]        w_x0, w_x1, w_z0, w_z1;
    logic [CELL_W+SIDE_W-1:0] w_row0, w_row1;
    t_job                     n_job;

    // Stall the whole pipe only when its last stage cannot drain.
    assign w_adv       = !r4_v || i_job_ready;
    assign i_in.ready  = w_adv;
    assign o_job_valid = r4_v;
    assign o_job       = r4_job;

    assign w_px = $signed(i_in.query_x) * $signed({1'b0, i_cfg.inv_world_size});
    assign w_pz = $signed(i_in.query_z) * $signed({1'b0, i_cfg.inv_world_size});

    assign w_w   = side_of(i_cfg.grid_width);
    assign w_h   = side_of(i_cfg.grid_height);
    assign w_wm1 = CELL_W'(w_w - SIDE_W'(1));
    assign w_hm1 = CELL_W'(w_h - SIDE_W'(1));

    assign w_x0 = r3_fx[32+CELL_W-1:32];
    assign w_z0 = r3_fz[32+CELL_W-1:32];
    assign w_x1 = (w_x0 < w_wm1) ? w_x0 + CELL_W'(1) : w_wm1;
    assign w_z1 = (w_z0 < w_hm1) ? w_z0 + CELL_W'(1) : w_hm1;

    assign w_row0 = (CELL_W+SIDE_W)'(w_z0) * (CELL_W+SIDE_W)'(w_w);
    assign w_row1 = (CELL_W+SIDE_W)'(w_z1) * (CELL_W+SIDE_W)'(w_w);

    always_comb begin
        n_job        = '0;
        n_job.kind   = r3_tag.kind;
        n_job.loaded = r3_tag.loaded;
        n_job.value  = r3_tag.value;
        n_job.tx     = r3_fx[31:16];
        n_job.tz     = r3_fz[31:16];
        if (r3_tag.kind == KIND_WRITE) begin
            n_job.addr[0] = r3_tag.idx;
        end else begin
            n_job.addr[0] = ADDR_W'(w_row0 + (CELL_W+SIDE_W)'(w_x0));
            n_job.addr[1] = ADDR_W'(w_row0 + (CELL_W+SIDE_W)'(w_x1));
            n_job.addr[2] = ADDR_W'(w_row1 + (CELL_W+SIDE_W)'(w_x0));
            n_job.addr[3] = ADDR_W'(w_row1 + (CELL_W+SIDE_W)'(w_x1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
        end else if (w_adv) begin
            if (i_in.valid && i_in.kind == KIND_WRITE) begin
                r_loaded <= 1'b1;
            end
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_tag.kind   <= t_kind'(i_in.kind);
            r1_tag.loaded <= r_loaded;
            r1_tag.idx    <= i_in.sample_index;
            r1_tag.value  <= i_in.sample_value;
            r1_px         <= w_px;
            r1_pz         <= w_pz;
            r2_tag        <= r1_tag;
            r2_ux         <= clamp_u(r1_px);
            r2_uz         <= clamp_u(r1_pz);
            r3_tag        <= r2_tag;
            r3_fx         <= F_W'(r2_ux) * F_W'(w_wm1);
            r3_fz         <= F_W'(r2_uz) * F_W'(w_hm1);
            r4_job        <= n_job;
        end
    end

endmodule

// ===== design/hfbs_queue.sv =====
// Short job queue between the front end and the memory sequencer.
// Depends on hfbs_pkg.
module hfbs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  hfbs_pkg::t_job    i_push_job,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output hfbs_pkg::t_job    o_pop_job,
    input  logic              i_pop_ready
);
    import hfbs_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              w_push, w_pop;

    assign o_push_ready = (r_cnt != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

// ===== design/hfbs_back.sv =====
// Back end: height memory, four-read sequencer, bilinear blend and result buffer.
// Depends on hfbs_pkg and hfbs_out_if.
module hfbs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  hfbs_pkg::t_job    i_job,
    output logic              o_job_ready,
    input  hfbs_pkg::t_cfg    i_cfg,
    hfbs_out_if.source        o_out
);
    import hfbs_pkg::*;

    logic [SAMPLE_BITS-1:0] r_store [2**ADDR_W];

    logic                   r_cur_v;
    t_job                   r_cur;
    logic [1:0]             r_step;
    logic [OPTR_W:0]        r_credit;

    logic                   r_rd_v, r_rd_zero;
    logic [1:0]             r_rd_tag;
    logic [FRAC_W-1:0]      r_rd_tx, r_rd_tz;
    logic [SAMPLE_BITS-1:0] r_rd_data;

    logic                   r_a_v, r_a_zero;
    logic [1:0]             r_a_tag;
    logic [FRAC_W-1:0]      r_a_tz;
    logic [ROW_W-1:0]       r_a_p;

    logic [ROW_W-1:0]       r_acc, r_top;
    logic                   r_b_v, r_b_zero;
    logic [ROW_W-1:0]       r_b_top, r_b_bot;
    logic [FRAC_W-1:0]      r_b_tz;

    logic                   r_c_v, r_c_zero;
    logic [MIXP_W-1:0]      r_c_m0, r_c_m1;

    logic                   r_d_v, r_d_zero;
    logic [MIX_W-1:0]       r_d_mix;

    logic                   r_e_v, r_e_zero;
    logic [RES_W-1:0]       r_e_prod;

    logic [HGT_W-1:0]       r_ob [OUT_DEPTH];
    logic [OPTR_W-1:0]      r_ob_wr, r_ob_rd;
    logic [OPTR_W:0]        r_ob_cnt;

    logic                   w_done, w_take, w_pop, w_pop_query, w_out_xfer;
    logic                   w_is_query;
    logic [FRAC_W:0]        w_wgt;
    logic [ROW_W-1:0]       w_row_sum;
    logic [MIXP_W-1:0]      w_mix_sum;
    logic [HGT_W-1:0]       w_height;

    assign w_is_query  = r_cur_v && (r_cur.kind == KIND_QUERY);
    assign w_done      = r_cur_v && ((r_cur.kind == KIND_WRITE) || (r_step == 2'd3));
    assign w_take      = !r_cur_v || w_done;
    // Start a query only when the result buffer has a slot reserved for it.
    assign o_job_ready = w_take &&
                         ((i_job.kind == KIND_WRITE) ||
                          (r_credit != (OPTR_W+1)'(OUT_DEPTH)));
    assign w_pop       = i_job_valid && o_job_ready;
    assign w_pop_query = w_pop && (i_job.kind == KIND_QUERY);
    assign w_out_xfer  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v  <= 1'b0;
            r_step   <= '0;
            r_credit <= '0;
        end else begin
            if (w_pop) begin
                r_cur_v <= 1'b1;
                r_step  <= '0;
            end else if (w_done) begin
                r_cur_v <= 1'b0;
            end else if (r_cur_v) begin
                r_step <= r_step + 2'd1;
            end
            if (w_pop_query && !w_out_xfer) begin
                r_credit <= r_credit + (OPTR_W+1)'(1);
            end else if (w_out_xfer && !w_pop_query) begin
                r_credit <= r_credit - (OPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cur <= i_job;
        end
    end

    // Height memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_cur_v && r_cur.kind == KIND_WRITE) begin
            r_store[r_cur.addr[0]] <= r_cur.value;
        end
        if (w_is_query) begin
            r_rd_data <= r_store[r_cur.addr[r_step]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_d_v  <= 1'b0;
            r_e_v  <= 1'b0;
        end else begin
            r_rd_v <= w_is_query;
            r_a_v  <= r_rd_v;
            r_b_v  <= r_a_v && (r_a_tag == 2'd3);
            r_c_v  <= r_b_v;
            r_d_v  <= r_c_v;
            r_e_v  <= r_d_v;
        end
    end

    // Odd steps read the far column and take weight t, even steps take 1 - t.
    assign w_wgt     = r_rd_tag[0] ? {1'b0, r_rd_tx} : ONE_FRAC - {1'b0, r_rd_tx};
    assign w_row_sum = r_acc + r_a_p;
    assign w_mix_sum = r_c_m0 + r_c_m1;

    always_ff @(posedge i_clk) begin
        r_rd_tag  <= r_step;
        r_rd_tx   <= r_cur.tx;
        r_rd_tz   <= r_cur.tz;
        r_rd_zero <= !r_cur.loaded;

        r_a_p    <= ROW_W'(r_rd_data) * ROW_W'(w_wgt);
        r_a_tag  <= r_rd_tag;
        r_a_tz   <= r_rd_tz;
        r_a_zero <= r_rd_zero;

        if (r_a_v) begin
            if (!r_a_tag[0]) begin
                r_acc <= r_a_p;
            end else if (r_a_tag == 2'd1) begin
                r_top <= w_row_sum;
            end
        end
        r_b_top  <= r_top;
        r_b_bot  <= w_row_sum;
        r_b_tz   <= r_a_tz;
        r_b_zero <= r_a_zero;

        r_c_m0   <= MIXP_W'(r_b_top) * MIXP_W'(ONE_FRAC - {1'b0, r_b_tz});
        r_c_m1   <= MIXP_W'(r_b_bot) * MIXP_W'(r_b_tz);
        r_c_zero <= r_b_zero;

        r_d_mix  <= w_mix_sum[MIX_W+FRAC_W-1:FRAC_W];
        r_d_zero <= r_c_zero;

        r_e_prod <= RES_W'(r_d_mix) * RES_W'(i_cfg.max_height);
        r_e_zero <= r_d_zero;
    end

    // The blend never exceeds full scale, so the top bits already saturate.
    assign w_height = r_e_zero ? '0 : r_e_prod[RES_W-1:MIX_W];

    assign o_out.valid  = (r_ob_cnt != '0);
    assign o_out.height = r_ob[r_ob_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr  <= '0;
            r_ob_rd  <= '0;
            r_ob_cnt <= '0;
        end else begin
            if (r_e_v) begin
                r_ob_wr <= r_ob_wr + OPTR_W'(1);
            end
            if (w_out_xfer) begin
                r_ob_rd <= r_ob_rd + OPTR_W'(1);
            end
            if (r_e_v && !w_out_xfer) begin
                r_ob_cnt <= r_ob_cnt + (OPTR_W+1)'(1);
            end else if (w_out_xfer && !r_e_v) begin
                r_ob_cnt <= r_ob_cnt - (OPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_e_v) begin
            r_ob[r_ob_wr] <= w_height;
        end
    end

endmodule

// ===== design/heightfield_bilinear_sample.sv =====
// Bilinear heightfield sampler: a 64K x 16 height store written one sample per
// item, and queries that return the bilinearly interpolated height in Q12.8
// metres. A query reads its four neighbouring samples one after another from
// the single-port height memory and holds the back end until all four are
// read, so the back end takes no new item before it is through with a query.
// A four-stage front end computes cell indexes and weights, and a 4-entry queue
// decouples it from the memory sequencer. Queries issued before any write
// return 0; reading a sample that was never written yields an arbitrary height.
// The store needs no clearing after reset. Configuration is written over the
// APB port, registers at byte offsets 0, 4, 8 and 12; the user must write it
// only while no item is in flight, as the block itself does not enforce this.
module heightfield_bilinear_sample (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hfbs_in_if.sink                         i_in,
    hfbs_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hfbs_pkg::PADDR_W-1:0]    paddr,
    input  logic [hfbs_pkg::PDATA_W-1:0]    pwdata,
    output logic [hfbs_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import hfbs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic     w_job_valid, w_job_ready, w_deq_valid, w_deq_ready;
    t_job     w_job, w_deq_job;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_world_size <= INV_RESET;
            r_cfg.max_height     <= MAXH_RESET;
            r_cfg.grid_width     <= SIDE_RESET;
            r_cfg.grid_height    <= SIDE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_INV_WORLD_SIZE: r_cfg.inv_world_size <= pwdata[INV_W-1:0];
                REG_MAX_HEIGHT:     r_cfg.max_height     <= pwdata[HGT_W-1:0];
                REG_GRID_WIDTH:     r_cfg.grid_width     <= pwdata[SIDE_W-1:0];
                REG_GRID_HEIGHT:    r_cfg.grid_height    <= pwdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INV_WORLD_SIZE: prdata = PDATA_W'(r_cfg.inv_world_size);
            REG_MAX_HEIGHT:     prdata = PDATA_W'(r_cfg.max_height);
            REG_GRID_WIDTH:     prdata = PDATA_W'(r_cfg.grid_width);
            REG_GRID_HEIGHT:    prdata = PDATA_W'(r_cfg.grid_height);
            default:            prdata = '0;
        endcase
    end

    hfbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_ready (w_job_ready)
    );

    hfbs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_job_valid),
        .i_push_job   (w_job),
        .o_push_ready (w_job_ready),
        .o_pop_valid  (w_deq_valid),
        .o_pop_job    (w_deq_job),
        .i_pop_ready  (w_deq_ready)
    );

    hfbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_deq_valid),
        .i_job       (w_deq_job),
        .o_job_ready (w_deq_ready),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

endmodule
